// ----- hw/rtl/gpioeid_pkg.sv -----
// Shared types and constants of the external interrupt detector.
package gpioeid_pkg;

    localparam int PINS_PER_PORT_DEF = 8;
    localparam int PORT_PINS         = 8;
    localparam int PEND_W            = 24;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int CTRL_W            = 16;
    localparam int TRIG_W            = 32;

    localparam logic [PEND_W-1:0]    MASK_RESET    = 24'hfffff0;
    localparam logic [PEND_W-1:0]    F_GROUP_BITS  = 24'h0000f0;
    localparam logic [PEND_W-1:0]    G_GROUP_BITS  = 24'hffff00;
    localparam logic [PORT_PINS-1:0] F_LEVEL_RESET = 8'h08;
    localparam logic [PORT_PINS-1:0] G_LEVEL_RESET = 8'hfe;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_F_EVENT = 2'd0,
        MODE_G_EVENT = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Pin modes in the control registers
    typedef enum logic [1:0] {
        PIN_INPUT    = 2'd0,
        PIN_OUTPUT   = 2'd1,
        PIN_IRQ      = 2'd2,
        PIN_RESERVED = 2'd3
    } pin_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_F_CONTROL = 3'd0,
        REG_G_CONTROL = 3'd1,
        REG_F_TRIGGER = 3'd2,
        REG_G_TRIGGER = 3'd3,
        REG_INT_MASK  = 3'd4
    } reg_idx_t;

    // Trigger kinds (low three bits of a pin's trigger field)
    localparam logic [2:0] KIND_LOW       = 3'd0;
    localparam logic [2:0] KIND_HIGH      = 3'd1;
    localparam logic [2:0] KIND_FALL_A    = 3'd2;
    localparam logic [2:0] KIND_FALL_B    = 3'd3;
    localparam logic [2:0] KIND_RISE_A    = 3'd4;
    localparam logic [2:0] KIND_RISE_B    = 3'd5;

    // Interrupt line codes for the group lines
    localparam logic [2:0] LINE_F_GROUP   = 3'd4;
    localparam logic [2:0] LINE_G_GROUP   = 3'd5;

    // Work the back end has to do for one item
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_LATCH  = 2'd1,
        OP_DETECT = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             port_g;
        logic [2:0]       pin;
        logic             level;
        logic [2:0]       kind;
        logic [PEND_W-1:0] clear_bits;
    } cmd_t;

    typedef struct packed {
        logic                 raise;
        logic [2:0]           raise_line;
        logic                 level_sensitive;
        logic                 drop_f_group;
        logic                 drop_g_group;
        logic [PEND_W-1:0]    pending_now;
        logic [PORT_PINS-1:0] port_f_levels;
        logic [PORT_PINS-1:0] port_g_levels;
    } res_t;

endpackage

// ----- hw/rtl/gpioeid_fifo.sv -----
// Small register queue used between the pipeline parts.
module gpioeid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ----- hw/rtl/gpioeid_front.sv -----
// Front end: classifies an incoming item against the pin configuration.
module gpioeid_front #(
    parameter int PINS_PER_PORT = gpioeid_pkg::PINS_PER_PORT_DEF
) (
    input  logic [1:0]                        mode,
    input  logic [2:0]                        pin,
    input  logic                              level,
    input  logic [gpioeid_pkg::PEND_W-1:0]    clear_bits,
    input  logic [gpioeid_pkg::CTRL_W-1:0]    port_f_control,
    input  logic [gpioeid_pkg::CTRL_W-1:0]    port_g_control,
    input  logic [gpioeid_pkg::TRIG_W-1:0]    port_f_trigger,
    input  logic [gpioeid_pkg::TRIG_W-1:0]    port_g_trigger,
    output gpioeid_pkg::cmd_t                 cmd
);
    import gpioeid_pkg::*;

    logic        pin_ok;
    logic        is_g;
    pin_mode_t   pin_mode;
    logic [2:0]  kind;

    // Pick the pin's control and trigger fields
    always_comb
    begin
        is_g     = (mode_t'(mode) == MODE_G_EVENT);
        pin_ok   = ({1'b0, pin} < 4'(PINS_PER_PORT));
        pin_mode = pin_mode_t'(is_g ? port_g_control[{pin, 1'b0} +: 2]
                                    : port_f_control[{pin, 1'b0} +: 2]);
        kind     = is_g ? port_g_trigger[{pin, 2'b00} +: 3]
                        : port_f_trigger[{pin, 2'b00} +: 3];
    end

    // Classify the item into back end work
    always_comb
    begin
        cmd.port_g     = is_g;
        cmd.pin        = pin;
        cmd.level      = level;
        cmd.kind       = kind;
        cmd.clear_bits = clear_bits;
        cmd.op         = OP_NONE;
        case (mode_t'(mode))
            MODE_F_EVENT, MODE_G_EVENT:
            begin
                if (pin_ok && pin_mode == PIN_INPUT)
                begin
                    cmd.op = OP_LATCH;
                end
                else if (pin_ok && pin_mode == PIN_IRQ)
                begin
                    cmd.op = OP_DETECT;
                end
            end
            MODE_CLEAR:
            begin
                cmd.op = OP_CLEAR;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end
endmodule

// ----- hw/rtl/gpioeid_back.sv -----
// Back end: holds pin levels and pending bits and forms the result.
module gpioeid_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  gpioeid_pkg::cmd_t              cmd,
    output logic                           cmd_pop,
    input  logic                           res_full,
    output logic                           res_push,
    output gpioeid_pkg::res_t              res,
    input  logic [gpioeid_pkg::PEND_W-1:0] int_mask
);
    import gpioeid_pkg::*;

    logic [PORT_PINS-1:0] f_levels_reg;
    logic [PORT_PINS-1:0] f_levels_next;
    logic [PORT_PINS-1:0] g_levels_reg;
    logic [PORT_PINS-1:0] g_levels_next;
    logic [PEND_W-1:0]    pending_reg;
    logic [PEND_W-1:0]    pending_next;
    logic [PORT_PINS-1:0] sel_levels;
    logic [PORT_PINS-1:0] upd_levels;
    logic [4:0]           set_idx;
    logic [PEND_W-1:0]    set_mask;
    logic                 changed;
    logic                 fire;
    logic                 is_level;

    assign cmd_pop  = cmd_valid && !res_full;
    assign res_push = cmd_pop;

    // Evaluate the trigger on the new level
    always_comb
    begin
        sel_levels          = cmd.port_g ? g_levels_reg : f_levels_reg;
        changed             = sel_levels[cmd.pin] ^ cmd.level;
        upd_levels          = sel_levels;
        upd_levels[cmd.pin] = cmd.level;
        set_idx             = cmd.port_g ? {2'b01, cmd.pin} : {2'b00, cmd.pin};
        set_mask            = PEND_W'(1) << set_idx;
        is_level            = 1'b0;
        case (cmd.kind) inside
            KIND_LOW:
            begin
                fire     = !cmd.level;
                is_level = 1'b1;
            end
            KIND_HIGH:
            begin
                fire     = cmd.level;
                is_level = 1'b1;
            end
            KIND_FALL_A, KIND_FALL_B:
            begin
                fire = changed && !cmd.level;
            end
            KIND_RISE_A, KIND_RISE_B:
            begin
                fire = changed && cmd.level;
            end
            default:
            begin
                fire = changed;
            end
        endcase
    end

    // Carry out the item
    always_comb
    begin
        f_levels_next       = f_levels_reg;
        g_levels_next       = g_levels_reg;
        pending_next        = pending_reg;
        res.raise           = 1'b0;
        res.raise_line      = '0;
        res.level_sensitive = 1'b0;
        res.drop_f_group    = 1'b0;
        res.drop_g_group    = 1'b0;
        case (cmd.op)
            OP_LATCH, OP_DETECT:
            begin
                if (cmd.port_g)
                begin
                    g_levels_next = upd_levels;
                end
                else
                begin
                    f_levels_next = upd_levels;
                end
                if (cmd.op == OP_DETECT && fire)
                begin
                    if (!cmd.port_g && !cmd.pin[2])
                    begin
                        res.raise           = 1'b1;
                        res.raise_line      = {1'b0, cmd.pin[1:0]};
                        res.level_sensitive = is_level;
                    end
                    else
                    begin
                        pending_next = pending_reg | set_mask;
                        if ((pending_next & ~int_mask) != '0)
                        begin
                            res.raise           = 1'b1;
                            res.raise_line      = cmd.port_g ? LINE_G_GROUP : LINE_F_GROUP;
                            res.level_sensitive = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR:
            begin
                pending_next     = pending_reg & ~cmd.clear_bits;
                res.drop_f_group = ((pending_next & F_GROUP_BITS) == '0);
                res.drop_g_group = ((pending_next & G_GROUP_BITS) == '0);
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
        res.pending_now   = pending_next;
        res.port_f_levels = f_levels_next;
        res.port_g_levels = g_levels_next;
    end

    // Hold state, update on each executed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_levels_reg <= F_LEVEL_RESET;
            g_levels_reg <= G_LEVEL_RESET;
            pending_reg  <= '0;
        end
        else if (cmd_pop)
        begin
            f_levels_reg <= f_levels_next;
            g_levels_reg <= g_levels_next;
            pending_reg  <= pending_next;
        end
    end
endmodule

// ----- hw/rtl/gpioeid_top.sv -----
// Top level of the external interrupt detector for ports F and G.
// The block takes one item per cycle while the command queue is not full and returns one
// result per item, in order. An accepted item is classified against the pin configuration,
// queued, and executed by the back end once the result queue has room, which then holds the
// result for popping. The rate is set by the back end, which updates levels and pending bits.
// Both sides sit behind two-entry queues, so a stalled consumer holds back the producer only
// once both queues are full. Control and trigger registers take effect for items pushed
// after the write; the interrupt mask takes effect for items executed after the write.
module gpio_external_interrupt_detect #(
    parameter int PINS_PER_PORT = gpioeid_pkg::PINS_PER_PORT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         mode,
    input  logic [2:0]                         pin,
    input  logic                               level,
    input  logic [gpioeid_pkg::PEND_W-1:0]     clear_bits,
    output logic                               empty,
    input  logic                               pop,
    output logic                               raise,
    output logic [2:0]                         raise_line,
    output logic                               level_sensitive,
    output logic                               drop_f_group,
    output logic                               drop_g_group,
    output logic [gpioeid_pkg::PEND_W-1:0]     pending_now,
    output logic [gpioeid_pkg::PORT_PINS-1:0]  port_f_levels,
    output logic [gpioeid_pkg::PORT_PINS-1:0]  port_g_levels,
    input  logic                               cfg_we,
    input  logic [gpioeid_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gpioeid_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gpioeid_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic [CTRL_W-1:0] f_control_reg;
    logic [CTRL_W-1:0] g_control_reg;
    logic [TRIG_W-1:0] f_trigger_reg;
    logic [TRIG_W-1:0] g_trigger_reg;
    logic [PEND_W-1:0] int_mask_reg;

    cmd_t  front_cmd;
    cmd_t  back_cmd;
    logic  cmd_empty;
    logic  cmd_pop;
    logic  res_full;
    logic  res_push;
    res_t  back_res;
    res_t  out_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_control_reg <= '0;
            g_control_reg <= '0;
            f_trigger_reg <= '0;
            g_trigger_reg <= '0;
            int_mask_reg  <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_F_CONTROL: f_control_reg <= cfg_wdata[CTRL_W-1:0];
                REG_G_CONTROL: g_control_reg <= cfg_wdata[CTRL_W-1:0];
                REG_F_TRIGGER: f_trigger_reg <= cfg_wdata[TRIG_W-1:0];
                REG_G_TRIGGER: g_trigger_reg <= cfg_wdata[TRIG_W-1:0];
                REG_INT_MASK:  int_mask_reg  <= cfg_wdata[PEND_W-1:0];
                default:       int_mask_reg  <= int_mask_reg;
            endcase
        end
    end

    gpioeid_front #(
        .PINS_PER_PORT (PINS_PER_PORT)
    ) u_front (
        .mode           (mode),
        .pin            (pin),
        .level          (level),
        .clear_bits     (clear_bits),
        .port_f_control (f_control_reg),
        .port_g_control (g_control_reg),
        .port_f_trigger (f_trigger_reg),
        .port_g_trigger (g_trigger_reg),
        .cmd            (front_cmd)
    );

    gpioeid_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    gpioeid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res),
        .int_mask  (int_mask_reg)
    );

    gpioeid_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign raise           = out_res.raise;
    assign raise_line      = out_res.raise_line;
    assign level_sensitive = out_res.level_sensitive;
    assign drop_f_group    = out_res.drop_f_group;
    assign drop_g_group    = out_res.drop_g_group;
    assign pending_now     = out_res.pending_now;
    assign port_f_levels   = out_res.port_f_levels;
    assign port_g_levels   = out_res.port_g_levels;

    // Only port F pins 4-7 and port G pins can ever be pending
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_now & ~(F_GROUP_BITS | 24'h00ff00)) == '0)
        else $error("pending bit outside the source range");

    // A result without a raise carries no line and no level flag
    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !raise) |-> (raise_line == '0 && !level_sensitive))
        else $error("line fields set without a raise");

    // Group lines are always reported as level sensitive
    a_group_level: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && raise && (raise_line == LINE_F_GROUP || raise_line == LINE_G_GROUP))
        |-> level_sensitive)
        else $error("group raise not level sensitive");

    // A drop of the F group means none of its bits is left
    a_drop_f: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && drop_f_group) |-> (pending_now & F_GROUP_BITS) == '0)
        else $error("F group dropped with bits pending");

    // The back end never executes into a full result queue
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");
endmodule
